/* rtl/pfbm_pkg.sv */
// Package for the 2D fractal Perlin noise block: widths, register map,
// sequencer states, status structs and small arithmetic helpers.
// Used by the multiplier, divider, sequencer and top level; depends on nothing.
package pfbm_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);
    localparam int PERM_W     = 8;
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W      = 4;
    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 20;
    localparam int FRAC_W     = 16;
    localparam int FADE_W     = 20;

    localparam int FREQ_W  = 48;
    localparam int AMP_W   = 41;
    localparam int ASUM_W  = 44;
    localparam int TOTAL_W = 64;
    localparam int LANE_W  = 22;
    localparam int POS_W   = 40;

    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [FREQ_W-1:0] FREQ_ONE = 48'h0000_0001_0000;
    localparam logic [FREQ_W-1:0] FREQ_CAP = 48'h7FFF_FFFF_FFFF;
    localparam logic [AMP_W-1:0]  AMP_ONE  = 41'h001_0000_0000;
    localparam logic [AMP_W-1:0]  AMP_CAP  = 41'h100_0000_0000;
    localparam logic signed [LANE_W-1:0] LANE_ONE = 22'sd65536;

    localparam logic signed [NOISE_W-1:0] NOISE_MAX = 20'sh7FFFF;
    localparam logic signed [NOISE_W-1:0] NOISE_MIN = 20'sh80000;

    // Register map, word index into the configuration space.
    localparam logic [1:0] REG_OCTAVES    = 2'd0;
    localparam logic [1:0] REG_LACUNARITY = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    localparam logic [OCT_W-1:0] OCTAVES_RST    = 4'd4;
    localparam logic [15:0]      LACUNARITY_RST = 16'd8192;
    localparam logic [15:0]      GAIN_RST       = 16'd16384;

    typedef struct packed {
        logic [OCT_W-1:0] octave_count;
        logic [15:0]      lacunarity;
        logic [15:0]      gain;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PX0, ST_PX1, ST_PY0, ST_PY1,
        ST_FX0, ST_FX1, ST_FX2, ST_FY0, ST_FY1, ST_FY2,
        ST_B1, ST_B2, ST_B3, ST_B4, ST_VAL,
        ST_ACC, ST_AMP, ST_FRQ, ST_NEXT, ST_DIV, ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                      idle;
        logic                      done;
        logic signed [NOISE_W-1:0] noise;
    } core_status_t;

    typedef struct packed {
        logic                      start;
        logic signed [TOTAL_W-1:0] dividend;
        logic [ASUM_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [NOISE_W-1:0] quotient;
    } div_rsp_t;

    // Eight-way gradient: +-u +-2v, with u and v swapped for the upper half.
    function automatic logic signed [LANE_W-1:0] grad(
        input logic [2:0]               h,
        input logic signed [LANE_W-1:0] dx,
        input logic signed [LANE_W-1:0] dy
    );
        logic signed [LANE_W-1:0] u;
        logic signed [LANE_W-1:0] v;
        logic signed [LANE_W-1:0] r;
        u = h[2] ? dy : dx;
        v = h[2] ? dx : dy;
        r = h[0] ? -u : u;
        r = h[1] ? (r - (v <<< 1)) : (r + (v <<< 1));
        return r;
    endfunction

    // Inner fade polynomial 6t^2 - 15t + 10 in Q16; always positive.
    function automatic logic [FADE_W-1:0] fade_poly(
        input logic [FRAC_W-1:0] t2,
        input logic [FRAC_W-1:0] t
    );
        logic [FADE_W:0] p;
        p = (21'(t2) * 21'd6) + 21'd655360 - (21'(t) * 21'd15);
        return p[FADE_W-1:0];
    endfunction

endpackage

/* rtl/pfbm_req_if.sv */
// Request channel of the fractal noise block: evaluate or table load.
// Depends on nothing.
interface pfbm_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         table_index;
    logic [7:0]         table_value;

    modport source(output valid, req_type, x_coord, y_coord, table_index, table_value,
                   input ready);
    modport sink(input valid, req_type, x_coord, y_coord, table_index, table_value,
                 output ready);
endinterface

/* rtl/pfbm_res_if.sv */
// Result channel of the fractal noise block: one noise value per evaluate.
// Depends on nothing.
interface pfbm_res_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] noise_value;

    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

/* rtl/pfbm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pfbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/pfbm_mul.sv */
// Shared signed multiplier of the noise sequencer, product registered.
// Depends on pfbm_pkg.
module pfbm_mul (
    input  logic                                 clk,
    input  logic signed [pfbm_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pfbm_pkg::MUL_B_W-1:0]  b,
    output logic signed [pfbm_pkg::MUL_P_W-1:0]  p
);
    import pfbm_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;
endmodule

/* rtl/pfbm_div.sv */
// Restoring divider for the final normalization: total over amplitude sum,
// truncated toward zero and saturated to Q3.16. Depends on pfbm_pkg.
module pfbm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pfbm_pkg::div_req_t req,
    output pfbm_pkg::div_rsp_t rsp
);
    import pfbm_pkg::*;

    localparam int Q_W = NOISE_W + 1;
    localparam int STEPS = Q_W + 1;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int DSH_W = ASUM_W + Q_W;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TOTAL_W-1:0]  rem_reg;
    logic [DSH_W-1:0]    dsh_reg;
    logic [Q_W-1:0]      q_reg;
    logic                neg_reg;
    logic                ovf_reg;
    logic                ge;
    logic [TOTAL_W-1:0]  mag;

    assign mag = req.dividend[TOTAL_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign ge  = {{(DSH_W - TOTAL_W){1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The first step only checks whether the quotient overflows its bits.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= mag;
            dsh_reg <= {req.divisor, {Q_W{1'b0}}};
            q_reg   <= '0;
            neg_reg <= req.dividend[TOTAL_W-1];
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (cnt_reg == CNT_W'(STEPS))
            begin
                ovf_reg <= ge;
            end
            else
            begin
                q_reg <= {q_reg[Q_W-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg[TOTAL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
        begin
            if (ovf_reg || (q_reg > Q_W'(2 ** (NOISE_W - 1))))
                rsp.quotient = NOISE_MIN;
            else
                rsp.quotient = -signed'(q_reg[NOISE_W-1:0]);
        end
        else
        begin
            if (ovf_reg || (q_reg > Q_W'(2 ** (NOISE_W - 1) - 1)))
                rsp.quotient = NOISE_MAX;
            else
                rsp.quotient = signed'(q_reg[NOISE_W-1:0]);
        end
    end
endmodule

/* rtl/pfbm_core.sv */
// Octave sequencer of the fractal noise block: drives the shared multiplier,
// walks the permutation table and hands the sums to the divider.
// Depends on pfbm_pkg, pfbm_mul and pfbm_div.
module pfbm_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pfbm_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pfbm_pkg::COORD_W-1:0]  y_coord,
    input  pfbm_pkg::cfg_t                       cfg,
    input  logic                                 out_free,
    output logic [pfbm_pkg::TBL_AW-1:0]          rd_addr,
    input  logic [pfbm_pkg::PERM_W-1:0]          rd_data,
    output pfbm_pkg::core_status_t               status
);
    import pfbm_pkg::*;

    seq_state_t state_reg, state_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic signed [COORD_W-1:0] xs_reg, ys_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic [AMP_W-1:0]          amp_reg;
    logic [ASUM_W-1:0]         asum_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [OCT_W-1:0]          oct_left_reg;
    logic [POS_W-1:0]          acc_reg;
    logic [TBL_AW-1:0]         xi_reg, yi_reg, pa_reg, pb_reg;
    logic [FRAC_W-1:0]         xf_reg, yf_reg, t2_reg;
    logic [FADE_W-1:0]         u_reg, v_reg;
    logic [2:0]                haa_reg, hab_reg, hba_reg, hbb_reg;
    logic signed [LANE_W-1:0]  x1_reg, x2_reg, val_reg;
    logic signed [NOISE_W-1:0] result_reg;

    logic [POS_W-1:0]          pos;
    logic [FRAC_W-1:0]         mul_q16;
    logic signed [LANE_W-1:0]  mul_hi;
    logic signed [LANE_W-1:0]  dx0, dx1, dy0, dy1;
    logic signed [LANE_W-1:0]  g_aa, g_ab, g_ba, g_bb;
    logic signed [LANE_W-1:0]  diff;
    logic signed [LANE_W-1:0]  n_sum;
    logic [AMP_W:0]            amp_prod;
    logic [FREQ_W+3:0]         freq_prod;
    logic [OCT_W-1:0]          oct_eff;

    pfbm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pfbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Position = low 40 bits of coordinate times frequency, from two partial
    // products and a correction for a negative coordinate.
    assign pos = acc_reg + {mul_p[15:0], 24'b0}
               - ((state_reg == ST_PY0 ? xs_reg[COORD_W-1] : ys_reg[COORD_W-1])
                  ? {freq_reg[7:0], 32'b0} : {POS_W{1'b0}});
    assign mul_q16   = mul_p[2*FRAC_W-1:FRAC_W];
    assign mul_hi    = mul_p[LANE_W+FRAC_W-1:FRAC_W];
    assign amp_prod  = mul_p[AMP_W+15:15];
    assign freq_prod = mul_p[FREQ_W+15:12];

    assign dx0 = signed'({{(LANE_W - FRAC_W){1'b0}}, xf_reg});
    assign dy0 = signed'({{(LANE_W - FRAC_W){1'b0}}, yf_reg});
    assign dx1 = dx0 - LANE_ONE;
    assign dy1 = dy0 - LANE_ONE;
    assign g_aa = grad(haa_reg, dx0, dy0);
    assign g_ba = grad(hba_reg, dx1, dy0);
    assign g_ab = grad(hab_reg, dx0, dy1);
    assign g_bb = grad(hbb_reg, dx1, dy1);
    assign n_sum = x1_reg + mul_hi;

    assign oct_eff = (cfg.octave_count == '0) ? OCT_W'(1)
                   : (cfg.octave_count > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                   : cfg.octave_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        mul_a            = '0;
        mul_b            = '0;
        diff             = '0;
        rd_addr          = xi_reg;
        div_req.start    = 1'b0;
        div_req.dividend = total_reg;
        div_req.divisor  = asum_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_PX0;
            end
            ST_PX0:
            begin
                mul_a = {17'b0, xs_reg};
                mul_b = {1'b0, freq_reg[23:0]};
                state_next = ST_PX1;
            end
            ST_PX1:
            begin
                mul_a = {17'b0, xs_reg};
                mul_b = {1'b0, freq_reg[47:24]};
                state_next = ST_PY0;
            end
            ST_PY0:
            begin
                mul_a = {17'b0, ys_reg};
                mul_b = {1'b0, freq_reg[23:0]};
                state_next = ST_PY1;
            end
            ST_PY1:
            begin
                mul_a = {17'b0, ys_reg};
                mul_b = {1'b0, freq_reg[47:24]};
                rd_addr = xi_reg;
                state_next = ST_FX0;
            end
            ST_FX0:
            begin
                mul_a = {33'b0, xf_reg};
                mul_b = {9'b0, xf_reg};
                rd_addr = xi_reg + 1'b1;
                state_next = ST_FX1;
            end
            ST_FX1:
            begin
                mul_a = {33'b0, mul_q16};
                mul_b = {9'b0, xf_reg};
                rd_addr = pa_reg + yi_reg;
                state_next = ST_FX2;
            end
            ST_FX2:
            begin
                mul_a = {33'b0, mul_q16};
                mul_b = {5'b0, fade_poly(t2_reg, xf_reg)};
                rd_addr = pa_reg + yi_reg + 1'b1;
                state_next = ST_FY0;
            end
            ST_FY0:
            begin
                mul_a = {33'b0, yf_reg};
                mul_b = {9'b0, yf_reg};
                rd_addr = pb_reg + yi_reg;
                state_next = ST_FY1;
            end
            ST_FY1:
            begin
                mul_a = {33'b0, mul_q16};
                mul_b = {9'b0, yf_reg};
                rd_addr = pb_reg + yi_reg + 1'b1;
                state_next = ST_FY2;
            end
            ST_FY2:
            begin
                mul_a = {33'b0, mul_q16};
                mul_b = {5'b0, fade_poly(t2_reg, yf_reg)};
                state_next = ST_B1;
            end
            ST_B1:
            begin
                diff  = g_ba - g_aa;
                mul_a = {{(MUL_A_W - LANE_W){diff[LANE_W-1]}}, diff};
                mul_b = {5'b0, u_reg};
                state_next = ST_B2;
            end
            ST_B2:
            begin
                diff  = g_bb - g_ab;
                mul_a = {{(MUL_A_W - LANE_W){diff[LANE_W-1]}}, diff};
                mul_b = {5'b0, u_reg};
                state_next = ST_B3;
            end
            ST_B3:
            begin
                state_next = ST_B4;
            end
            ST_B4:
            begin
                diff  = x2_reg - x1_reg;
                mul_a = {{(MUL_A_W - LANE_W){diff[LANE_W-1]}}, diff};
                mul_b = {5'b0, v_reg};
                state_next = ST_VAL;
            end
            ST_VAL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                mul_a = {8'b0, amp_reg};
                mul_b = {{(MUL_B_W - LANE_W){val_reg[LANE_W-1]}}, val_reg};
                state_next = ST_AMP;
            end
            ST_AMP:
            begin
                mul_a = {8'b0, amp_reg};
                mul_b = {9'b0, cfg.gain};
                state_next = ST_FRQ;
            end
            ST_FRQ:
            begin
                mul_a = {1'b0, freq_reg};
                mul_b = {9'b0, cfg.lacunarity};
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (oct_left_reg == OCT_W'(1))
                begin
                    div_req.start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_PX0;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath captures: each state takes the product issued one state earlier.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    xs_reg       <= x_coord;
                    ys_reg       <= y_coord;
                    freq_reg     <= FREQ_ONE;
                    amp_reg      <= AMP_ONE;
                    asum_reg     <= '0;
                    total_reg    <= '0;
                    oct_left_reg <= oct_eff;
                end
            end
            ST_PX1: acc_reg <= mul_p[POS_W-1:0];
            ST_PY0:
            begin
                xi_reg <= pos[POS_W-1:32];
                xf_reg <= pos[31:16];
            end
            ST_PY1: acc_reg <= mul_p[POS_W-1:0];
            ST_FX0:
            begin
                yi_reg <= pos[POS_W-1:32];
                yf_reg <= pos[31:16];
                pa_reg <= rd_data;
            end
            ST_FX1:
            begin
                t2_reg <= mul_q16;
                pb_reg <= rd_data;
            end
            ST_FX2: haa_reg <= rd_data[2:0];
            ST_FY0:
            begin
                u_reg   <= mul_p[FADE_W+15:16];
                hab_reg <= rd_data[2:0];
            end
            ST_FY1:
            begin
                t2_reg  <= mul_q16;
                hba_reg <= rd_data[2:0];
            end
            ST_FY2: hbb_reg <= rd_data[2:0];
            ST_B1:  v_reg <= mul_p[FADE_W+15:16];
            ST_B2:  x1_reg <= g_aa + mul_hi;
            ST_B3:  x2_reg <= g_ab + mul_hi;
            ST_VAL: val_reg <= (n_sum + LANE_ONE) >>> 1;
            ST_AMP:
            begin
                total_reg <= total_reg + mul_p[TOTAL_W-1:0];
                asum_reg  <= asum_reg + ASUM_W'(amp_reg);
            end
            ST_FRQ:
            begin
                amp_reg <= (amp_prod > (AMP_W + 1)'(AMP_CAP)) ? AMP_CAP
                                                              : amp_prod[AMP_W-1:0];
            end
            ST_NEXT:
            begin
                freq_reg     <= (freq_prod > (FREQ_W + 4)'(FREQ_CAP)) ? FREQ_CAP
                                                                      : freq_prod[FREQ_W-1:0];
                oct_left_reg <= oct_left_reg - 1'b1;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    result_reg <= div_rsp.quotient;
            end
            default:
            begin
            end
        endcase
    end

    assign status.idle  = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_DONE);
    assign status.noise = result_reg;
endmodule

/* rtl/perlin_fbm_noise_2d.sv */
// Top level of the 2D fractal Perlin noise block: configuration registers,
// permutation table, octave sequencer and result register.
// Depends on pfbm_pkg, pfbm_req_if, pfbm_res_if, pfbm_ram and pfbm_core.
//
// Usage. Requests arrive on the req channel; a transfer with req_type set
// loads one permutation entry and produces no result, a transfer with
// req_type clear evaluates fractal noise at (x_coord, y_coord) and produces
// exactly one noise_value transfer on the res channel. Software must load
// all 256 table entries before the first evaluation. The APB port holds
// octave_count, lacunarity and gain at byte addresses 0, 4 and 8; write them
// only while no evaluation is in flight.
// Timing. A table load leaves the sequencer idle, so it is ready again at once.
// An evaluation runs through one shared multiplier: each octave steps through
// ST_PX0 to ST_NEXT, then the divider runs its 22 steps and flags the
// quotient, which enters the output register as res.valid rises. req.ready
// stays low while the evaluation runs and returns in the cycle that res.valid
// rises, so no further request is accepted until the evaluation has finished.
// Reset clears the sequencer, the divider and the result valid flag and
// restores the register defaults (4 octaves, lacunarity 2.0, gain 0.5); the
// table contents are not cleared. If the receiver stalls, the finished result
// waits in the output register and the block still takes one new request;
// that evaluation then holds its result until the register frees up.
module perlin_fbm_noise_2d (
    input  logic                          clk,
    input  logic                          rst_n,
    pfbm_req_if.sink                      req,
    pfbm_res_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfbm_pkg::APB_AW-1:0]   paddr,
    input  logic [pfbm_pkg::APB_DW-1:0]   pwdata,
    output logic [pfbm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import pfbm_pkg::*;

    cfg_t                      cfg_reg;
    logic                      res_valid_reg;
    logic signed [NOISE_W-1:0] noise_reg;
    core_status_t              status;
    logic [TBL_AW-1:0]         rd_addr;
    logic [PERM_W-1:0]         rd_data;
    logic                      req_fire;
    logic                      out_free;
    logic                      apb_write;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    // Configuration registers; writes to unmapped words are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_count <= OCTAVES_RST;
            cfg_reg.lacunarity   <= LACUNARITY_RST;
            cfg_reg.gain         <= GAIN_RST;
        end
        else if (apb_write)
        begin
            case (paddr[3:2])
                REG_OCTAVES:    cfg_reg.octave_count <= pwdata[OCT_W-1:0];
                REG_LACUNARITY: cfg_reg.lacunarity   <= pwdata[15:0];
                REG_GAIN:       cfg_reg.gain         <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_OCTAVES:    prdata = {{(APB_DW - OCT_W){1'b0}}, cfg_reg.octave_count};
            REG_LACUNARITY: prdata = {16'b0, cfg_reg.lacunarity};
            REG_GAIN:       prdata = {16'b0, cfg_reg.gain};
            default:        prdata = '0;
        endcase
    end

    // The sequencer only takes a request while it is idle.
    assign req.ready = status.idle;
    assign req_fire  = req.valid && req.ready;

    pfbm_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .clk     (clk),
        .wr_en   (req_fire && req.req_type),
        .wr_addr (req.table_index),
        .wr_data (req.table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !res_valid_reg || res.ready;

    pfbm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_fire && !req.req_type),
        .x_coord  (req.x_coord),
        .y_coord  (req.y_coord),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .status   (status)
    );

    // Output register: filled when the sequencer finishes and the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (status.done && out_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && out_free)
            noise_reg <= status.noise;
    end

    assign res.valid       = res_valid_reg;
    assign res.noise_value = noise_reg;
endmodule

/* tb/sv/pfbm_tb_pkg.sv */
// Shared types for the fractal noise testbench: the request item record.
// Depends on nothing.
package pfbm_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {REQ_EVAL = 1'b0, REQ_LOAD = 1'b1} req_kind_t;

    typedef struct packed {
        req_kind_t          kind;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
    } noise_req_t;
endpackage

/* tb/sv/perlin_fbm_noise_2d_tb.sv */
// Self-checking testbench for perlin_fbm_noise_2d: loads the permutation
// table, evaluates fractal noise under several register settings and checks
// each result against a fixed-point predictor. Depends on pfbm_pkg,
// pfbm_tb_pkg, pfbm_req_if, pfbm_res_if and the RTL.
module perlin_fbm_noise_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfbm_pkg::*;
    import pfbm_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    pfbm_req_if req_ch ();
    pfbm_res_if res_ch ();

    perlin_fbm_noise_2d i_dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Mirror of the block's state: the table on each load transfer, the settings on each register write.
    logic [7:0]  perm_mirror [TABLE_SIZE];
    logic [3:0]  oct_setting = OCTAVES_RST;
    logic [15:0] lac_setting = LACUNARITY_RST;
    logic [15:0] gain_setting = GAIN_RST;

    noise_req_t             pending_reqs[$];
    logic signed [19:0]     expected_noise[$];
    int                     mismatches = 0;
    int                     issued = 0;
    bit                     stim_done = 1'b0;

    // Floor division by 2^s of a signed value.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fade(longint t);
        longint t2, t3, poly;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        poly = 6 * t2 + 10 * 65536 - 15 * t;
        return (t3 * poly) >>> 16;
    endfunction

    function automatic longint grad_dot(int h, longint dx, longint dy);
        longint u, v, r;
        u = (h & 4) ? dy : dx;
        v = (h & 4) ? dx : dy;
        r = (h & 1) ? -u : u;
        r = (h & 2) ? r - 2 * v : r + 2 * v;
        return r;
    endfunction

    function automatic longint mix(longint a, longint b, longint t);
        return a + floor_shr((b - a) * t, 16);
    endfunction

    function automatic int perm_at(int i);
        return perm_mirror[i & 8'hFF];
    endfunction

    // Octave value in Q16 for a scaled point held as Q.32 products mod 2^64.
    function automatic longint octave_value(logic [63:0] px, logic [63:0] py);
        int xi, yi, pa, pb, aa, ab, ba, bb;
        longint xf, yf, u, v, x1, x2, n;
        xi = px[39:32];
        yi = py[39:32];
        xf = px[31:16];
        yf = py[31:16];
        u = fade(xf);
        v = fade(yf);
        pa = perm_at(xi);
        pb = perm_at(xi + 1);
        aa = perm_at(pa + yi);
        ab = perm_at(pa + yi + 1);
        ba = perm_at(pb + yi);
        bb = perm_at(pb + yi + 1);
        x1 = mix(grad_dot(aa, xf, yf), grad_dot(ba, xf - 65536, yf), u);
        x2 = mix(grad_dot(ab, xf, yf - 65536), grad_dot(bb, xf - 65536, yf - 65536), u);
        n = mix(x1, x2, v);
        return floor_shr(n + 65536, 1);
    endfunction

    function automatic logic signed [19:0] predict_noise(noise_req_t r);
        int count;
        logic [63:0] xs, ys, freq, amp, amp_sum;
        logic [63:0] total;
        longint val, quo;
        count = oct_setting;
        if (count < 1) count = 1;
        if (count > MAX_OCTAVES) count = MAX_OCTAVES;
        xs = {{32{r.x_coord[31]}}, r.x_coord};
        ys = {{32{r.y_coord[31]}}, r.y_coord};
        freq = 64'd65536;
        amp = 64'd1 << 32;
        amp_sum = '0;
        total = '0;
        for (int i = 0; i < count; i++) begin
            val = octave_value(xs * freq, ys * freq);
            total = total + 64'(val * longint'(amp));
            amp_sum = amp_sum + amp;
            amp = (amp * gain_setting) >> 15;
            if (amp > (64'd1 << 40)) amp = 64'd1 << 40;
            freq = (freq * lac_setting) >> 12;
            if (freq > ((64'd1 << 47) - 1)) freq = (64'd1 << 47) - 1;
        end
        quo = longint'(total) / longint'(amp_sum);
        if (quo > 524287) quo = 524287;
        if (quo < -524288) quo = -524288;
        return quo[19:0];
    endfunction

    // Request driver: random gap before each item, then hold until transfer.
    int req_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= 1'b0;
            req_ch.x_coord <= '0;
            req_ch.y_coord <= '0;
            req_ch.table_index <= '0;
            req_ch.table_value <= '0;
            req_gap <= $urandom_range(0, 15);
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                // Accepted: update the mirror and predict before state changes.
                if (req_ch.req_type == REQ_LOAD)
                    perm_mirror[req_ch.table_index] = req_ch.table_value;
                else
                    expected_noise.push_back(predict_noise(noise_req_t'{
                        REQ_EVAL, req_ch.x_coord, req_ch.y_coord,
                        req_ch.table_index, req_ch.table_value}));
                issued++;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // Still waiting for the transfer.
            end else if (req_gap > 0) begin
                req_ch.valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                noise_req_t nx;
                nx = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.req_type <= nx.kind;
                req_ch.x_coord <= nx.x_coord;
                req_ch.y_coord <= nx.y_coord;
                req_ch.table_index <= nx.table_index;
                req_ch.table_value <= nx.table_value;
                req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with a random stall drawn per result.
    int res_stall = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall <= $urandom_range(0, 15);
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_noise.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, res_ch.noise_value);
                    mismatches++;
                end else begin
                    logic signed [19:0] want;
                    want = expected_noise.pop_front();
                    if (want !== res_ch.noise_value) begin
                        $display("%0t: noise_value expected %0d, actual %0d",
                                 $time, want, res_ch.noise_value);
                        mismatches++;
                    end
                end
                res_ch.ready <= 1'b0;
                res_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end else if (res_stall > 0) begin
                res_ch.ready <= 1'b0;
                res_stall <= res_stall - 1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OCTAVES:    oct_setting = value[3:0];
            REG_LACUNARITY: lac_setting = value[15:0];
            default:        gain_setting = value[15:0];
        endcase
    endtask

    // Wait until every queued item has transferred and every result arrived,
    // plus a margin longer than the block's longest evaluation.
    task automatic drain(input int target);
        while (issued < target || expected_noise.size() > 0 || req_ch.valid)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    function automatic noise_req_t eval_req(logic signed [31:0] x, logic signed [31:0] y);
        return noise_req_t'{REQ_EVAL, x, y, 8'($urandom), 8'($urandom)};
    endfunction

    function automatic logic signed [31:0] rand_coord();
        // Mostly modest coordinates, sometimes the full range.
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endfunction

    int total_sent = 0;

    task automatic queue_item(noise_req_t r);
        pending_reqs.push_back(r);
        total_sent++;
    endtask

    initial begin
        logic [7:0] shuffle [256];
        int j;
        logic [7:0] tmp;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Load a shuffled table so every entry is written before any evaluation.
        for (int i = 0; i < 256; i++) shuffle[i] = i[7:0];
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            queue_item(noise_req_t'{REQ_LOAD, $urandom, $urandom, i[7:0], shuffle[i]});

        // Directed evaluations at reset settings: field extremes and origin.
        queue_item(eval_req(0, 0));
        queue_item(eval_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        queue_item(eval_req(32'sh8000_0000, 32'sh8000_0000));
        queue_item(eval_req(32'sh7FFF_FFFF, 32'sh8000_0000));
        queue_item(eval_req(32'sh0000_8000, 32'shFFFF_8000));
        queue_item(eval_req(32'sh0001_0000, 32'sh0000_FFFF));
        queue_item(noise_req_t'{REQ_LOAD, 0, 0, 8'hFF, 8'hFF});
        queue_item(noise_req_t'{REQ_LOAD, 0, 0, 8'h00, 8'h00});
        queue_item(eval_req(32'sh0003_4567, 32'sh0012_abcd));
        drain(total_sent);

        // Settings sweep including extremes: octave count 0, 1, 8 and 15,
        // lacunarity zero and maximum, gain zero and one.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(REG_OCTAVES, 0); write_reg(REG_LACUNARITY, 0);
                         write_reg(REG_GAIN, 0); end
                1: begin write_reg(REG_OCTAVES, 8); write_reg(REG_LACUNARITY, 16'hFFFF);
                         write_reg(REG_GAIN, 32768); end
                2: begin write_reg(REG_OCTAVES, 15); write_reg(REG_LACUNARITY, 0);
                         write_reg(REG_GAIN, 32768); end
                3: begin write_reg(REG_OCTAVES, 1); write_reg(REG_LACUNARITY, 4096);
                         write_reg(REG_GAIN, 16384); end
                4: begin write_reg(REG_OCTAVES, 4); write_reg(REG_LACUNARITY, 8192);
                         write_reg(REG_GAIN, 16384); end
                default: begin
                    write_reg(REG_OCTAVES, $urandom_range(0, 15));
                    write_reg(REG_LACUNARITY, $urandom_range(0, 65535));
                    write_reg(REG_GAIN, $urandom_range(0, 32768));
                end
            endcase
            for (int k = 0; k < 140; k++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_item(noise_req_t'{REQ_LOAD, $urandom, $urandom,
                                            8'($urandom), 8'($urandom)});
                else
                    queue_item(eval_req(rand_coord(), rand_coord()));
            end
            drain(total_sent);
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pfbm_pkg.sv
rtl/pfbm_req_if.sv
rtl/pfbm_res_if.sv
rtl/pfbm_ram.sv
rtl/pfbm_mul.sv
rtl/pfbm_div.sv
rtl/pfbm_core.sv
rtl/perlin_fbm_noise_2d.sv
tb/sv/pfbm_tb_pkg.sv
tb/sv/perlin_fbm_noise_2d_tb.sv
